[src/table_cell_grid_placer_defines.svh]
// Assertion macros for the checker file of the table cell grid placer.
// Depends on clk and arst_n being visible where a macro is used.
`ifndef TABLE_CELL_GRID_PLACER_DEFINES_SVH
`define TABLE_CELL_GRID_PLACER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCGP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tcgp check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCGP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tcgp check failed");

`endif

[src/tcgp_pkg.sv]
// Shared constants, codes and result type of the table cell grid placer.
// No dependencies.
`timescale 1ns / 1ps
package tcgp_pkg;
	localparam int MAX_COLS = 4096;
	localparam int ADDR_W   = 12;
	localparam int COL_W    = 13;
	localparam int ROW_W    = 16;

	localparam logic [9:0]  MAX_COL_SPAN  = 10'd1000;
	localparam logic [15:0] MAX_ROW_SPAN  = 16'd65534;
	localparam logic [12:0] MAX_COLS_C    = 13'd4096;
	localparam logic [31:0] MAX_CELLS_RST = 32'd1048576;

	localparam logic [2:0] CMD_TABLE = 3'd0;
	localparam logic [2:0] CMD_GROUP = 3'd1;
	localparam logic [2:0] CMD_ROW   = 3'd2;
	localparam logic [2:0] CMD_CELL  = 3'd3;
	localparam logic [2:0] CMD_REND  = 3'd4;
	localparam logic [2:0] CMD_TEND  = 3'd5;

	localparam logic [1:0] KIND_CELL  = 2'd0;
	localparam logic [1:0] KIND_ROW   = 2'd1;
	localparam logic [1:0] KIND_TABLE = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_OVERLAP = 2'd1;
	localparam logic [1:0] ST_WIDE    = 2'd2;
	localparam logic [1:0] ST_LARGE   = 2'd3;

	localparam logic [1:0] GK_BODY    = 2'd1;
	localparam logic [1:0] GK_INVALID = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  status;
		logic [15:0] row_index;
		logic [12:0] col_index;
		logic [15:0] row_extent;
		logic [9:0]  col_extent;
		logic [19:0] cell_number;
		logic [15:0] cell_in_row;
		logic [1:0]  row_group_kind;
		logic        all_headers;
		logic [31:0] slots_needed;
	} res_t;
endpackage

[src/tcgp_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module tcgp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[src/table_cell_grid_placer.sv]
// Table cell grid placer: one item at a time; a result beat is valid at the edge ending its item.
// Row start, unused codes and items after an error need no further state; table start runs a
// serial divide unless the row count is zero, and group start writes every grid column. A placed
// cell skips columns still held, checks its width, checks each spanned column inside the grid for
// overlap, then writes each spanned column; a failing cell ends at the check that fails.
// An emit holds while the previous beat waits. Reset clears control state, not the column store.
`timescale 1ns / 1ps
module table_cell_grid_placer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [15:0] row_count,
	input  logic [1:0]  group_kind,
	input  logic [9:0]  col_span,
	input  logic        row_span_given,
	input  logic [15:0] row_span,
	input  logic        is_header,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [1:0]  status,
	output logic [15:0] row_index,
	output logic [12:0] col_index,
	output logic [15:0] row_extent,
	output logic [9:0]  col_extent,
	output logic [19:0] cell_number,
	output logic [15:0] cell_in_row,
	output logic [1:0]  row_group_kind,
	output logic        all_headers,
	output logic [12:0] column_count,
	output logic [31:0] slots_needed
);
	typedef enum logic [3:0] {
		S_IDLE, S_DIV, S_GRP, S_SKIP, S_SKIPW, S_CHK, S_OVL, S_OVLW, S_WR,
		S_TEND, S_TEND2, S_EMIT
	} state_t;

	state_t state_q;

	logic [31:0] max_cells_q, width_cap_q, quo_q, slots_q;
	logic [15:0] rem_q, table_rows_q, cur_row_q, grp_end_q, cells_q, hdrs_q;
	logic [15:0] span_r_q;
	logic [12:0] cursor_q, grid_w_q, j_q, last_q;
	logic [9:0]  cs_q;
	logic [19:0] placed_q;
	logic [1:0]  gk_q;
	logic [4:0]  cnt_q;
	logic        err_q, out_valid_q;
	tcgp_pkg::res_t res_q, out_q;
	logic [12:0] col_count_q;

	logic                         mem_we;
	logic [tcgp_pkg::ADDR_W-1:0]  mem_waddr, mem_raddr;
	logic [15:0]                  mem_wdata, mem_rdata;

	logic        accept;
	logic        emit_go;
	logic [16:0] trial, grp_sum, fr_sum;
	logic        trial_ge;
	logic [15:0] rs_eff, avail, span_new, cells_inc, fr;
	logic [12:0] last_c;
	logic        wide;
	logic [28:0] wide_slots;
	logic [28:0] tend_slots;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign emit_go  = (state_q == S_EMIT) && (!out_valid_q || out_ready);

	// serial restoring divide step
	assign trial    = {rem_q, quo_q[31]};
	assign trial_ge = trial >= {1'b0, table_rows_q};

	assign grp_sum  = {1'b0, cur_row_q} + {1'b0, row_count};

	always_comb begin
		if (!row_span_given) begin
			rs_eff = 16'd1;
		end else if (row_span > tcgp_pkg::MAX_ROW_SPAN) begin
			rs_eff = tcgp_pkg::MAX_ROW_SPAN;
		end else begin
			rs_eff = row_span;
		end
		avail = grp_end_q - cur_row_q;
		if (grp_end_q > cur_row_q) begin
			span_new = (rs_eff == 16'd0 || rs_eff > avail) ? avail : rs_eff;
		end else begin
			span_new = 16'd1;
		end
	end

	assign cells_inc  = (cells_q < 16'hFFFF) ? cells_q + 16'd1 : cells_q;
	assign last_c     = cursor_q + {3'b000, cs_q};
	assign wide       = ({19'd0, last_c} > width_cap_q) || (last_c > tcgp_pkg::MAX_COLS_C);
	assign wide_slots = last_c * table_rows_q;
	assign tend_slots = grid_w_q * table_rows_q;
	assign fr_sum     = {1'b0, cur_row_q} + {1'b0, span_r_q};
	assign fr         = fr_sum[16] ? 16'hFFFF : fr_sum[15:0];

	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = cur_row_q;
		if (state_q == S_GRP) begin
			mem_we = 1'b1;
		end else if (state_q == S_WR && j_q < last_q) begin
			mem_we    = 1'b1;
			mem_wdata = fr;
		end
		mem_waddr = j_q[tcgp_pkg::ADDR_W-1:0];
		mem_raddr = (state_q == S_SKIP) ? cursor_q[tcgp_pkg::ADDR_W-1:0]
			: j_q[tcgp_pkg::ADDR_W-1:0];
	end

	tcgp_ram #(.WIDTH(16), .DEPTH(tcgp_pkg::MAX_COLS)) u_col_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			max_cells_q  <= tcgp_pkg::MAX_CELLS_RST;
			width_cap_q  <= '0;
			quo_q        <= '0;
			slots_q      <= '0;
			rem_q        <= '0;
			table_rows_q <= '0;
			cur_row_q    <= '0;
			grp_end_q    <= '0;
			cells_q      <= '0;
			hdrs_q       <= '0;
			span_r_q     <= '0;
			cursor_q     <= '0;
			grid_w_q     <= '0;
			j_q          <= '0;
			last_q       <= '0;
			cs_q         <= '0;
			placed_q     <= '0;
			gk_q         <= '0;
			cnt_q        <= '0;
			err_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			res_q        <= '0;
			out_q        <= '0;
			col_count_q  <= '0;
		end else begin
			if (cfg_we) begin
				max_cells_q <= cfg_wdata;
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cmd == tcgp_pkg::CMD_TABLE) begin
							table_rows_q <= row_count;
							cur_row_q    <= '0;
							grp_end_q    <= '0;
							cursor_q     <= '0;
							grid_w_q     <= '0;
							cells_q      <= '0;
							hdrs_q       <= '0;
							placed_q     <= '0;
							gk_q         <= '0;
							err_q        <= 1'b0;
							if (row_count == 16'd0) begin
								width_cap_q <= max_cells_q;
							end else begin
								quo_q   <= max_cells_q;
								rem_q   <= '0;
								cnt_q   <= 5'd31;
								state_q <= S_DIV;
							end
						end else if (!err_q) begin
							case (cmd)
								tcgp_pkg::CMD_GROUP: begin
									grp_end_q <= grp_sum[16] ? 16'hFFFF : grp_sum[15:0];
									gk_q <= (group_kind == tcgp_pkg::GK_INVALID) ?
										tcgp_pkg::GK_BODY : group_kind;
									j_q <= '0;
									if (grid_w_q != '0) begin
										state_q <= S_GRP;
									end
								end
								tcgp_pkg::CMD_ROW: begin
									cursor_q <= '0;
									cells_q  <= '0;
									hdrs_q   <= '0;
								end
								tcgp_pkg::CMD_CELL: begin
									cells_q <= cells_inc;
									if (is_header && hdrs_q < 16'hFFFF) begin
										hdrs_q <= hdrs_q + 16'd1;
									end
									if (col_span == 10'd0) begin
										cs_q <= 10'd1;
									end else if (col_span > tcgp_pkg::MAX_COL_SPAN) begin
										cs_q <= tcgp_pkg::MAX_COL_SPAN;
									end else begin
										cs_q <= col_span;
									end
									span_r_q <= span_new;
									res_q.kind           <= tcgp_pkg::KIND_CELL;
									res_q.status         <= tcgp_pkg::ST_OK;
									res_q.row_index      <= cur_row_q;
									res_q.row_extent     <= span_new;
									res_q.cell_number    <= placed_q;
									res_q.cell_in_row    <= cells_inc;
									res_q.row_group_kind <= gk_q;
									res_q.all_headers    <= 1'b0;
									res_q.slots_needed   <= '0;
									state_q <= S_SKIP;
								end
								tcgp_pkg::CMD_REND: begin
									res_q.kind           <= tcgp_pkg::KIND_ROW;
									res_q.status         <= tcgp_pkg::ST_OK;
									res_q.row_index      <= cur_row_q;
									res_q.col_index      <= '0;
									res_q.row_extent     <= '0;
									res_q.col_extent     <= '0;
									res_q.cell_number    <= '0;
									res_q.cell_in_row    <= cells_q;
									res_q.row_group_kind <= gk_q;
									res_q.all_headers    <= (cells_q != '0) && (hdrs_q == cells_q);
									res_q.slots_needed   <= '0;
									if (cur_row_q < 16'hFFFF) begin
										cur_row_q <= cur_row_q + 16'd1;
									end
									cursor_q <= '0;
									cells_q  <= '0;
									hdrs_q   <= '0;
									state_q  <= S_EMIT;
								end
								tcgp_pkg::CMD_TEND: begin
									state_q <= S_TEND;
								end
								default: begin
									// unused codes: drop
								end
							endcase
						end
					end
				end
				S_DIV: begin
					rem_q <= trial_ge ? 16'(trial - {1'b0, table_rows_q}) : trial[15:0];
					quo_q <= {quo_q[30:0], trial_ge};
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						width_cap_q <= {quo_q[30:0], trial_ge};
						state_q     <= S_IDLE;
					end
				end
				S_GRP: begin
					j_q <= j_q + 13'd1;
					if (j_q + 13'd1 == grid_w_q) begin
						state_q <= S_IDLE;
					end
				end
				S_SKIP: begin
					state_q <= (cursor_q < grid_w_q) ? S_SKIPW : S_CHK;
				end
				S_SKIPW: begin
					if (mem_rdata > cur_row_q) begin
						cursor_q <= cursor_q + 13'd1;
						state_q  <= S_SKIP;
					end else begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					res_q.col_index  <= cursor_q;
					res_q.col_extent <= cs_q;
					last_q <= last_c;
					j_q    <= cursor_q;
					if (wide) begin
						err_q              <= 1'b1;
						res_q.status       <= tcgp_pkg::ST_WIDE;
						res_q.slots_needed <= {3'b000, wide_slots};
						state_q            <= S_EMIT;
					end else begin
						state_q <= S_OVL;
					end
				end
				S_OVL: begin
					if (j_q < last_q && j_q < grid_w_q) begin
						state_q <= S_OVLW;
					end else begin
						j_q     <= cursor_q;
						state_q <= S_WR;
					end
				end
				S_OVLW: begin
					if (mem_rdata > cur_row_q) begin
						err_q        <= 1'b1;
						res_q.status <= tcgp_pkg::ST_OVERLAP;
						state_q      <= S_EMIT;
					end else begin
						j_q     <= j_q + 13'd1;
						state_q <= S_OVL;
					end
				end
				S_WR: begin
					if (j_q < last_q) begin
						j_q <= j_q + 13'd1;
					end else begin
						if (last_q > grid_w_q) begin
							grid_w_q <= last_q;
						end
						placed_q <= placed_q + 20'd1;
						cursor_q <= last_q;
						state_q  <= S_EMIT;
					end
				end
				S_TEND: begin
					slots_q <= {3'b000, tend_slots};
					state_q <= S_TEND2;
				end
				S_TEND2: begin
					res_q.kind           <= tcgp_pkg::KIND_TABLE;
					res_q.row_index      <= '0;
					res_q.col_index      <= '0;
					res_q.row_extent     <= '0;
					res_q.col_extent     <= '0;
					res_q.cell_number    <= '0;
					res_q.cell_in_row    <= '0;
					res_q.row_group_kind <= '0;
					res_q.all_headers    <= 1'b0;
					if (slots_q > max_cells_q) begin
						err_q              <= 1'b1;
						res_q.status       <= tcgp_pkg::ST_LARGE;
						res_q.slots_needed <= slots_q;
					end else begin
						res_q.status       <= tcgp_pkg::ST_OK;
						res_q.slots_needed <= '0;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					// hold until the output register is free
					if (emit_go) begin
						out_q       <= res_q;
						col_count_q <= grid_w_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = out_q.kind;
	assign status         = out_q.status;
	assign row_index      = out_q.row_index;
	assign col_index      = out_q.col_index;
	assign row_extent     = out_q.row_extent;
	assign col_extent     = out_q.col_extent;
	assign cell_number    = out_q.cell_number;
	assign cell_in_row    = out_q.cell_in_row;
	assign row_group_kind = out_q.row_group_kind;
	assign all_headers    = out_q.all_headers;
	assign column_count   = col_count_q;
	assign slots_needed   = out_q.slots_needed;
endmodule

[src/tcgp_checker.sv]
// Port-level checks of the table cell grid placer, bound to the top level.
// Depends on tcgp_pkg and table_cell_grid_placer_defines.svh.
`timescale 1ns / 1ps
`include "table_cell_grid_placer_defines.svh"
module tcgp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  kind,
	input logic [1:0]  status,
	input logic [15:0] row_index,
	input logic [12:0] col_index,
	input logic [9:0]  col_extent,
	input logic [31:0] slots_needed
);
	`TCGP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`TCGP_ASSERT_NOW(a_ok_no_slots, out_valid && status == tcgp_pkg::ST_OK, slots_needed == 32'd0)
	`TCGP_ASSERT_NOW(a_table_zero, out_valid && kind == tcgp_pkg::KIND_TABLE, row_index == 16'd0 && col_index == 13'd0)
	`TCGP_ASSERT_NOW(a_cell_span, out_valid && kind == tcgp_pkg::KIND_CELL, col_extent != 10'd0)
endmodule

bind table_cell_grid_placer tcgp_checker u_tcgp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.kind         (kind),
	.status       (status),
	.row_index    (row_index),
	.col_index    (col_index),
	.col_extent   (col_extent),
	.slots_needed (slots_needed)
);

[tb/tb_table_cell_grid_placer.sv]
// Self-checking testbench for the table cell grid placer: a directed table of
// beats, then random tables, checked against a grid predictor kept in this file.
// Depends on tcgp_pkg and table_cell_grid_placer.
`timescale 1ns / 1ps
module tb_table_cell_grid_placer;
	localparam int LIMIT      = 3000000;
	localparam int DRAIN_WAIT = 5000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  status;
		logic [15:0] row_index;
		logic [12:0] col_index;
		logic [15:0] row_extent;
		logic [9:0]  col_extent;
		logic [19:0] cell_number;
		logic [15:0] cell_in_row;
		logic [1:0]  row_group_kind;
		logic        all_headers;
		logic [12:0] column_count;
		logic [31:0] slots_needed;
	} placement_t;

	typedef struct {
		logic [2:0]  c;
		logic [15:0] rc;
		logic [1:0]  gk;
		logic [9:0]  cs;
		logic        rsg;
		logic [15:0] rs;
		logic        hdr;
		bit          typed;
		placement_t  res;
	} beat_t;

	logic clk, arst_n, cfg_we;
	logic [31:0] cfg_wdata;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [2:0] cmd;
	logic [15:0] row_count, row_span, row_index, row_extent, cell_in_row;
	logic [1:0] group_kind, kind, status, row_group_kind;
	logic [9:0] col_span, col_extent;
	logic row_span_given, is_header, all_headers;
	logic [12:0] col_index, column_count;
	logic [19:0] cell_number;
	logic [31:0] slots_needed;

	table_cell_grid_placer u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .row_count(row_count),
		.group_kind(group_kind), .col_span(col_span), .row_span_given(row_span_given),
		.row_span(row_span), .is_header(is_header), .out_valid(out_valid),
		.out_ready(out_ready), .kind(kind), .status(status), .row_index(row_index),
		.col_index(col_index), .row_extent(row_extent), .col_extent(col_extent),
		.cell_number(cell_number), .cell_in_row(cell_in_row),
		.row_group_kind(row_group_kind), .all_headers(all_headers),
		.column_count(column_count), .slots_needed(slots_needed)
	);

	// predictor state
	logic [15:0] col_free [tcgp_pkg::MAX_COLS];
	int unsigned cur_row = 0, grp_end = 0, cursor = 0, width = 0, cap = 0, trows = 0;
	int unsigned row_cells = 0, row_hdrs = 0, placed = 0, grp_kind = 0;
	int unsigned max_cells_cfg = tcgp_pkg::MAX_CELLS_RST;
	bit          latched = 0;

	placement_t  pending_placements[$];
	int          errors = 0, cycles = 0, accepted = 0, idle_pct, stall_pct;
	bit          typed_flag;
	placement_t  typed_res;

	function automatic placement_t mk(int unsigned k, st, r, c, re, ce, n, ir, g, ah, slots);
		placement_t p;
		p.kind = 2'(k); p.status = 2'(st); p.row_index = 16'(r); p.col_index = 13'(c);
		p.row_extent = 16'(re); p.col_extent = 10'(ce); p.cell_number = 20'(n);
		p.cell_in_row = 16'(ir); p.row_group_kind = 2'(g); p.all_headers = 1'(ah);
		p.column_count = 13'(width);
		p.slots_needed = slots;
		return p;
	endfunction

	function automatic int unsigned sat32(longint unsigned v);
		return (v > 64'hFFFFFFFF) ? 32'hFFFFFFFF : 32'(v);
	endfunction

	function automatic bit place_item(logic [2:0] c, logic [15:0] rc, logic [1:0] gk,
			logic [9:0] cs_in, logic rsg, logic [15:0] rs_in, logic hdr,
			output placement_t p);
		int unsigned cur, cs, rs, span_r, fr, inrow;
		longint unsigned last, slots;
		p = '0;
		if (c == tcgp_pkg::CMD_TABLE) begin
			trows = rc;
			cap = rc > 0 ? max_cells_cfg / rc : max_cells_cfg;
			cur_row = 0; grp_end = 0; cursor = 0; width = 0; row_cells = 0;
			row_hdrs = 0; placed = 0; grp_kind = 0; latched = 0;
			return 0;
		end
		if (latched || c > tcgp_pkg::CMD_TEND)
			return 0;
		case (c)
			tcgp_pkg::CMD_GROUP: begin
				for (int j = 0; j < width; j++)
					col_free[j] = 16'(cur_row);
				grp_end = (cur_row + rc > 65535) ? 65535 : cur_row + rc;
				grp_kind = (gk == tcgp_pkg::GK_INVALID) ? tcgp_pkg::GK_BODY : gk;
				return 0;
			end
			tcgp_pkg::CMD_ROW: begin
				cursor = 0; row_cells = 0; row_hdrs = 0;
				return 0;
			end
			tcgp_pkg::CMD_CELL: begin
				if (row_cells < 65535) row_cells++;
				if (hdr && row_hdrs < 65535) row_hdrs++;
				inrow = row_cells;
				cur = cursor;
				// skip columns still held by spans from rows above
				while (cur < width && col_free[cur] > cur_row)
					cur++;
				cursor = cur;
				cs = cs_in == 0 ? 1 : (cs_in > tcgp_pkg::MAX_COL_SPAN ?
					tcgp_pkg::MAX_COL_SPAN : cs_in);
				rs = !rsg ? 1 : (rs_in > tcgp_pkg::MAX_ROW_SPAN ? tcgp_pkg::MAX_ROW_SPAN : rs_in);
				if (grp_end > cur_row)
					span_r = (rs == 0 || rs > grp_end - cur_row) ? grp_end - cur_row : rs;
				else
					span_r = 1;
				last = cur + cs;
				if (last > cap || last > tcgp_pkg::MAX_COLS) begin
					latched = 1;
					p = mk(tcgp_pkg::KIND_CELL, tcgp_pkg::ST_WIDE, cur_row, cur, span_r, cs,
						placed, inrow, grp_kind, 0, sat32(last * trows));
					return 1;
				end
				for (int j = cur; j < last; j++)
					if (j < width && col_free[j] > cur_row) begin
						latched = 1;
						p = mk(tcgp_pkg::KIND_CELL, tcgp_pkg::ST_OVERLAP, cur_row, cur, span_r,
							cs, placed, inrow, grp_kind, 0, 0);
						return 1;
					end
				fr = (cur_row + span_r > 65535) ? 65535 : cur_row + span_r;
				for (int j = cur; j < last; j++)
					col_free[j] = 16'(fr);
				if (last > width) width = 32'(last);
				p = mk(tcgp_pkg::KIND_CELL, tcgp_pkg::ST_OK, cur_row, cur, span_r, cs, placed,
					inrow, grp_kind, 0, 0);
				placed = (placed + 1) & 20'hFFFFF;
				cursor = 32'(last);
				return 1;
			end
			tcgp_pkg::CMD_REND: begin
				p = mk(tcgp_pkg::KIND_ROW, tcgp_pkg::ST_OK, cur_row, 0, 0, 0, 0, row_cells,
					grp_kind, row_cells > 0 && row_hdrs == row_cells, 0);
				if (cur_row < 65535) cur_row++;
				cursor = 0; row_cells = 0; row_hdrs = 0;
				return 1;
			end
			default: begin
				slots = longint'(trows) * width;
				if (slots > max_cells_cfg) begin
					latched = 1;
					p = mk(tcgp_pkg::KIND_TABLE, tcgp_pkg::ST_LARGE, 0, 0, 0, 0, 0, 0, 0, 0,
						sat32(slots));
				end else
					p = mk(tcgp_pkg::KIND_TABLE, tcgp_pkg::ST_OK, 0, 0, 0, 0, 0, 0, 0, 0, 0);
				return 1;
			end
		endcase
	endfunction

	task automatic compare_placement(placement_t e, placement_t a);
		string names [12] = '{"kind", "status", "row_index", "col_index", "row_extent",
			"col_extent", "cell_number", "cell_in_row", "row_group_kind", "all_headers",
			"column_count", "slots_needed"};
		longint unsigned ev [12], av [12];
		ev = '{e.kind, e.status, e.row_index, e.col_index, e.row_extent, e.col_extent,
			e.cell_number, e.cell_in_row, e.row_group_kind, e.all_headers,
			e.column_count, e.slots_needed};
		av = '{a.kind, a.status, a.row_index, a.col_index, a.row_extent, a.col_extent,
			a.cell_number, a.cell_in_row, a.row_group_kind, a.all_headers,
			a.column_count, a.slots_needed};
		for (int i = 0; i < 12; i++)
			if (ev[i] != av[i]) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $realtime,
					names[i], ev[i], av[i]);
			end
	endtask

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		placement_t p, got;
		cycles++;
		if (cycles > LIMIT) begin
			$display("table_cell_grid_placer regression: fail");
			$finish;
		end
		if (out_valid && out_ready) begin
			got = '{kind, status, row_index, col_index, row_extent, col_extent,
				cell_number, cell_in_row, row_group_kind, all_headers, column_count,
				slots_needed};
			if (pending_placements.size() == 0) begin
				errors++;
				$display("%0t: result beat with none expected, kind %0d", $realtime, kind);
			end else
				compare_placement(pending_placements.pop_front(), got);
		end
		if (in_valid && in_ready) begin
			accepted++;
			if (place_item(cmd, row_count, group_kind, col_span, row_span_given,
					row_span, is_header, p))
				pending_placements.push_back(typed_flag ? typed_res : p);
		end
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	task automatic send(beat_t b);
		int n;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		typed_flag = b.typed;
		typed_res = b.res;
		in_valid <= 1;
		cmd <= b.c; row_count <= b.rc; group_kind <= b.gk; col_span <= b.cs;
		row_span_given <= b.rsg; row_span <= b.rs; is_header <= b.hdr;
		n = accepted;
		do @(negedge clk); while (accepted == n);
	endtask

	task automatic send_plain(logic [2:0] c, logic [15:0] rc = 0, logic [1:0] gk = 0,
			logic [9:0] cs = 0, logic rsg = 0, logic [15:0] rs = 0, logic hdr = 0);
		send('{c, rc, gk, cs, rsg, rs, hdr, 0, '0});
	endtask

	// hold until nothing is pending and the block has had time for silent items
	task automatic drain();
		in_valid <= 0;
		while (pending_placements.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic write_max_cells(logic [31:0] v);
		cfg_we <= 1;
		cfg_wdata <= v;
		max_cells_cfg = v;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic random_cell();
		logic [9:0] cs;
		logic [15:0] rs;
		cs = ($urandom_range(99) < 5) ? 10'($urandom_range(1023)) : 10'($urandom_range(3));
		rs = ($urandom_range(99) < 5) ? 16'($urandom_range(65535)) : 16'($urandom_range(4));
		send_plain(tcgp_pkg::CMD_CELL, 16'($urandom_range(65535)), 2'($urandom_range(3)), cs,
			1'($urandom_range(1)), rs, 1'($urandom_range(1)));
	endtask

	task automatic random_table(inout int count);
		int pick;
		pick = $urandom_range(99);
		send_plain(tcgp_pkg::CMD_TABLE, 16'(pick < 5 ? 0 : (pick < 10 ? $urandom_range(65535)
			: $urandom_range(1, 12))));
		count++;
		repeat ($urandom_range(1, 3)) begin
			send_plain(tcgp_pkg::CMD_GROUP, 16'($urandom_range(99) < 5 ? $urandom_range(65535)
				: $urandom_range(0, 5)), 2'($urandom_range(3)));
			count++;
			repeat ($urandom_range(1, 4)) begin
				if ($urandom_range(9) != 0) begin
					send_plain(tcgp_pkg::CMD_ROW);
					count++;
				end
				repeat ($urandom_range(0, 4)) begin
					random_cell();
					count++;
				end
				// noise: any command, any field
				if ($urandom_range(99) < 5) begin
					send_plain(3'($urandom_range(7)), 16'($urandom_range(65535)),
						2'($urandom_range(3)), 10'($urandom_range(1023)),
						1'($urandom_range(1)), 16'($urandom_range(65535)),
						1'($urandom_range(1)));
					count++;
				end
				send_plain(tcgp_pkg::CMD_REND);
				count++;
			end
		end
		send_plain(tcgp_pkg::CMD_TEND);
		count++;
	endtask

	beat_t directed [] ;
	int unsigned phase_cfg [8] = '{tcgp_pkg::MAX_CELLS_RST, 0, 32'hFFFFFFFF, 40, 200, 0, 1, 7};

	initial begin
		int count;
		arst_n = 0; cfg_we = 0; cfg_wdata = 0; in_valid = 0;
		cmd = 0; row_count = 0; group_kind = 0; col_span = 0; row_span_given = 0;
		row_span = 0; is_header = 0;
		idle_pct = 0; stall_pct = 0; typed_flag = 0;
		repeat (6) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		directed = '{
			// row end and table end straight after reset
			'{tcgp_pkg::CMD_REND, 0, 0, 0, 0, 0, 0, 1,
				'{tcgp_pkg::KIND_ROW, tcgp_pkg::ST_OK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}},
			'{tcgp_pkg::CMD_TEND, 0, 0, 0, 0, 0, 0, 1,
				'{tcgp_pkg::KIND_TABLE, tcgp_pkg::ST_OK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}},
			'{tcgp_pkg::CMD_TABLE, 16'hFFFF, 0, 0, 0, 0, 0, 0, '0},
			'{tcgp_pkg::CMD_ROW, 0, 0, 0, 0, 0, 0, 0, '0},
			// cap is 1048576 / 65535 = 16, so a full-width cell is too wide
			'{tcgp_pkg::CMD_CELL, 0, 0, 10'd1000, 0, 0, 1, 1,
				'{tcgp_pkg::KIND_CELL, tcgp_pkg::ST_WIDE, 0, 0, 1, 10'd1000, 0, 1, 0, 0, 0,
				32'd65535000}},
			'{tcgp_pkg::CMD_REND, 0, 0, 0, 0, 0, 0, 0, '0},
			'{3'd6, 0, 0, 0, 0, 0, 0, 0, '0},
			'{tcgp_pkg::CMD_TABLE, 4, 0, 0, 0, 0, 0, 0, '0},
			'{tcgp_pkg::CMD_GROUP, 4, 0, 0, 0, 0, 0, 0, '0},
			'{tcgp_pkg::CMD_ROW, 0, 0, 0, 0, 0, 0, 0, '0},
			'{tcgp_pkg::CMD_CELL, 0, 0, 0, 0, 0, 1, 0, '0},
			'{tcgp_pkg::CMD_CELL, 0, 0, 10'd1, 1, 16'd2, 1, 0, '0},
			'{tcgp_pkg::CMD_CELL, 0, 0, 10'd2, 1, 16'd0, 0, 0, '0},
			'{tcgp_pkg::CMD_REND, 0, 0, 0, 0, 0, 0, 0, '0},
			'{3'd7, 16'hFFFF, 3, 10'h3FF, 1, 16'hFFFF, 1, 0, '0},
			'{tcgp_pkg::CMD_GROUP, 16'hFFFF, tcgp_pkg::GK_INVALID, 0, 0, 0, 0, 0, '0},
			'{tcgp_pkg::CMD_ROW, 0, 0, 0, 0, 0, 0, 0, '0},
			'{tcgp_pkg::CMD_CELL, 0, 0, 10'h3FF, 1, 16'hFFFF, 1, 0, '0},
			'{tcgp_pkg::CMD_CELL, 0, 0, 10'd1, 0, 0, 0, 0, '0},
			'{tcgp_pkg::CMD_REND, 0, 0, 0, 0, 0, 0, 0, '0},
			'{tcgp_pkg::CMD_ROW, 0, 0, 0, 0, 0, 0, 0, '0},
			// the wide span from the row above still holds columns 0 to 999: the cell skips to column 1000
			'{tcgp_pkg::CMD_CELL, 0, 0, 10'd2, 0, 0, 0, 0, '0},
			'{tcgp_pkg::CMD_TEND, 0, 0, 0, 0, 0, 0, 0, '0},
			'{tcgp_pkg::CMD_TABLE, 0, 0, 0, 0, 0, 0, 0, '0},
			'{tcgp_pkg::CMD_TEND, 0, 0, 0, 0, 0, 0, 0, '0}
		};
		foreach (directed[i])
			send(directed[i]);
		typed_flag = 0;
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			idle_pct  = (ph % 4 == 1) ? 48 : (ph % 4 == 3) ? 29 : 0;
			stall_pct = (ph % 4 == 2) ? 48 : (ph % 4 == 3) ? 29 : 0;
			write_max_cells(ph == 5 ? $urandom : phase_cfg[ph]);
			count = 0;
			while (count < 85)
				random_table(count);
			drain();
		end

		if (errors == 0)
			$display("table_cell_grid_placer regression: pass");
		else
			$display("table_cell_grid_placer regression: fail");
		$finish;
	end
endmodule

[table_cell_grid_placer.f]
+incdir+src
src/tcgp_pkg.sv
src/tcgp_ram.sv
src/table_cell_grid_placer.sv
src/tcgp_checker.sv
tb/tb_table_cell_grid_placer.sv
